// ===== rtl/aik_pkg.sv =====
// shared types, widths and constants of the arm inverse kinematics pipeline
// used by aik_sqrt, aik_div, aik_cordic and the arm_inverse_kinematics top level
package aik_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int ANG_SH          = 16 - ANGLE_FRAC_BITS;

    localparam int IN_W   = 18;
    localparam int OUT_W  = 18;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    // square root unit: radicand up to 2^48, root up to 2^24
    localparam int SQ_IN_W  = 50;
    localparam int SQ_OUT_W = 25;

    // divider: magnitude and divisor, quotient in q.24 no larger than 1.0
    localparam int DIV_W = 37;
    localparam int Q_W   = 25;

    // cordic vector and angle widths, angle in q.16 degrees
    localparam int CW = 40;
    localparam int ZW = 26;
    localparam int CO_LAT = CORDIC_STEPS + 1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LINK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOREARM_LINK = 2'd2;

    localparam logic [CFG_W-1:0] RST_BASE_HEIGHT  = 16'd3277;
    localparam logic [CFG_W-1:0] RST_UPPER_LINK   = 16'd11796;
    localparam logic [CFG_W-1:0] RST_FOREARM_LINK = 16'd18350;

    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(90 * 65536);

    localparam logic signed [ZW-1:0] ATAN_DEG_Q16 [24] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    localparam logic signed [ZW+1:0] RND_HALF = (ZW+2)'(1) <<< (ANG_SH - 1);
    localparam logic signed [ZW+1:0] SAT_HI   = (ZW+2)'(131071);
    localparam logic signed [ZW+1:0] SAT_LO   = -(ZW+2)'(131072);

    typedef struct packed {
        logic                   valid;
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W:0]   l2;
        logic [36:0]            dsq;
        logic [32:0]            upf;
        logic signed [32:0]     umf;
        logic [31:0]            uf;
    } t_sq_side;

    typedef struct packed {
        logic                   valid;
        logic                   bad;
        logic                   neg_e;
        logic                   neg_s;
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic [IN_W-1:0]        l1;
        logic signed [IN_W:0]   l2;
    } t_dv_side;

    typedef struct packed {
        logic                   valid;
        logic                   bad;
        logic signed [Q_W:0]    ce;
        logic signed [Q_W:0]    cs;
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic [IN_W-1:0]        l1;
        logic signed [IN_W:0]   l2;
    } t_ac_side;

    typedef struct packed {
        logic valid;
        logic bad;
    } t_co_side;

    // round half up to the output fraction and clamp to the field range
    function automatic logic [OUT_W-1:0] to_output(input logic signed [ZW:0] z);
        logic signed [ZW+1:0] sum;
        logic signed [ZW+1:0] r;
        sum = (ZW+2)'(z) + RND_HALF;
        r   = sum >>> ANG_SH;
        if (r > SAT_HI) begin
            r = SAT_HI;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
        end
        return r[OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/aik_sqrt.sv =====
// pipelined floor square root, one result bit per stage
// depends on aik_pkg for the radicand and root widths
module aik_sqrt import aik_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SQ_IN_W-1:0] i_rad,
    output logic [SQ_OUT_W-1:0] o_root
);

    logic [SQ_IN_W-1:0]  r_rem  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] r_root [SQ_OUT_W];

    for (genvar s = 0; s < SQ_OUT_W; s++) begin : g_stage
        localparam int K = SQ_OUT_W - 1 - s;
        logic [SQ_IN_W-1:0]  rem_prev;
        logic [SQ_OUT_W-1:0] root_prev;
        logic [SQ_IN_W-1:0]  trial;
        logic [SQ_IN_W-1:0]  n_rem;
        logic [SQ_OUT_W-1:0] n_root;

        if (s == 0) begin : g_first
            assign rem_prev  = i_rad;
            assign root_prev = '0;
        end else begin : g_next
            assign rem_prev  = r_rem[s-1];
            assign root_prev = r_root[s-1];
        end

        // (root + 2^k)^2 - root^2, root holding only bits above k
        assign trial = (SQ_IN_W'(root_prev) << (K + 1)) | (SQ_IN_W'(1) << (2 * K));

        always_comb begin
            if (rem_prev >= trial) begin
                n_rem  = rem_prev - trial;
                n_root = root_prev | (SQ_OUT_W'(1) << K);
            end else begin
                n_rem  = rem_prev;
                n_root = root_prev;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
            end
        end
    end

    assign o_root = r_root[SQ_OUT_W-1];

endmodule

// ===== rtl/aik_div.sv =====
// pipelined restoring divider giving a q.24 quotient of a magnitude not above its divisor
// depends on aik_pkg for widths
module aik_div import aik_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DIV_W-1:0] i_mag,
    input  logic [DIV_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    logic [DIV_W-1:0] r_rem [Q_W];
    logic [DIV_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int K = Q_W - 1 - s;
        logic [DIV_W:0]   rem_sh;
        logic [DIV_W-1:0] den_prev;
        logic [Q_W-1:0]   quo_prev;
        logic [DIV_W:0]   n_rem;
        logic [Q_W-1:0]   n_quo;

        if (s == 0) begin : g_first
            assign rem_sh   = {1'b0, i_mag};
            assign den_prev = i_den;
            assign quo_prev = '0;
        end else begin : g_next
            assign rem_sh   = {r_rem[s-1], 1'b0};
            assign den_prev = r_den[s-1];
            assign quo_prev = r_quo[s-1];
        end

        always_comb begin
            if (rem_sh >= {1'b0, den_prev}) begin
                n_rem = rem_sh - {1'b0, den_prev};
                n_quo = quo_prev | (Q_W'(1) << K);
            end else begin
                n_rem = rem_sh;
                n_quo = quo_prev;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem[DIV_W-1:0];
                r_den[s] <= den_prev;
                r_quo[s] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

// ===== rtl/aik_cordic.sv =====
// pipelined cordic in vectoring mode giving atan2(y, x) in q.16 degrees
// depends on aik_pkg for widths, step count and the arctangent table
module aik_cordic import aik_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic signed [ZW-1:0] o_ang
);

    logic signed [CW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] r_z [CORDIC_STEPS+1];

    logic signed [CW-1:0] n_x0;
    logic signed [CW-1:0] n_y0;
    logic signed [ZW-1:0] n_z0;

    // quarter-turn pre-rotation brings x into the right half plane
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = QUARTER_TURN;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
        end
    end

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [ZW-1:0] n_z;

        always_comb begin
            n_x = r_x[s];
            n_y = r_y[s];
            n_z = r_z[s];
            if (r_y[s] > 0) begin
                n_x = r_x[s] + (r_y[s] >>> s);
                n_y = r_y[s] - (r_x[s] >>> s);
                n_z = r_z[s] + ATAN_DEG_Q16[s];
            end else if (r_y[s] < 0) begin
                n_x = r_x[s] - (r_y[s] >>> s);
                n_y = r_y[s] + (r_x[s] >>> s);
                n_z = r_z[s] - ATAN_DEG_Q16[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s+1] <= n_x;
                r_y[s+1] <= n_y;
                r_z[s+1] <= n_z;
            end
        end
    end

    assign o_ang = r_z[CORDIC_STEPS];

endmodule

// ===== rtl/arm_inverse_kinematics.sv =====
// arm_inverse_kinematics: one target point in, base, shoulder and elbow angles out.
// The block takes one point per clock while the output is not stalled. A point passes
// 103 register stages, the last being the output register. The stages are: stages a to
// d for squares and sums, a 25-stage square root for reach and distance, stages e and f
// for the law-of-cosines terms, a 25-stage divider, stages h, i and j forming 1 - c^2, a
// second 25-stage square root, a 17-stage cordic for the four arctangents, stage l for
// the shoulder subtraction, and rounding into the output register. A stall on the output
// holds the whole chain, but a bubble just before the output register still lets a new
// point in. Depends on aik_pkg, aik_sqrt, aik_div and aik_cordic.
module arm_inverse_kinematics import aik_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // target point requests
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,  // target_x, target_y, target_z, zero pad
    // joint angle results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,  // base_angle, shoulder_angle, elbow_angle, pad
    output logic                 m_axis_tuser   // unreachable
);

    logic [CFG_W-1:0] r_base_height;
    logic [CFG_W-1:0] r_upper_link;
    logic [CFG_W-1:0] r_forearm_link;

    logic en;
    logic out_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_height  <= RST_BASE_HEIGHT;
            r_upper_link   <= RST_UPPER_LINK;
            r_forearm_link <= RST_FOREARM_LINK;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BASE_HEIGHT:  r_base_height  <= i_cfg_data;
                REG_UPPER_LINK:   r_upper_link   <= i_cfg_data;
                REG_FOREARM_LINK: r_forearm_link <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage a: unpack and height above the shoulder
    logic                   r_a_valid;
    logic signed [IN_W-1:0] r_a_x;
    logic signed [IN_W-1:0] r_a_y;
    logic signed [IN_W:0]   r_a_l2;
    logic signed [IN_W-1:0] in_z;

    assign in_z = s_axis_tdata[53:36];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= s_axis_tvalid;
        end
        if (en) begin
            r_a_x  <= s_axis_tdata[17:0];
            r_a_y  <= s_axis_tdata[35:18];
            r_a_l2 <= (IN_W+1)'(in_z) - $signed({3'b0, r_base_height});
        end
    end

    // stage b: squares
    logic                   r_b_valid;
    logic signed [IN_W-1:0] r_b_x;
    logic signed [IN_W-1:0] r_b_y;
    logic signed [IN_W:0]   r_b_l2;
    logic [34:0]            r_b_xx;
    logic [34:0]            r_b_yy;
    logic [35:0]            r_b_ll;
    logic [31:0]            r_b_uu;
    logic [31:0]            r_b_ff;
    logic [31:0]            r_b_uf;
    logic signed [35:0]     n_xx;
    logic signed [35:0]     n_yy;
    logic signed [37:0]     n_ll;

    assign n_xx = r_a_x * r_a_x;
    assign n_yy = r_a_y * r_a_y;
    assign n_ll = r_a_l2 * r_a_l2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
        if (en) begin
            r_b_x  <= r_a_x;
            r_b_y  <= r_a_y;
            r_b_l2 <= r_a_l2;
            r_b_xx <= n_xx[34:0];
            r_b_yy <= n_yy[34:0];
            r_b_ll <= n_ll[35:0];
            r_b_uu <= {16'b0, r_upper_link} * {16'b0, r_upper_link};
            r_b_ff <= {16'b0, r_forearm_link} * {16'b0, r_forearm_link};
            r_b_uf <= {16'b0, r_upper_link} * {16'b0, r_forearm_link};
        end
    end

    // stage c: planar reach squared and link terms
    logic                   r_c_valid;
    logic signed [IN_W-1:0] r_c_x;
    logic signed [IN_W-1:0] r_c_y;
    logic signed [IN_W:0]   r_c_l2;
    logic [35:0]            r_c_rsq;
    logic [35:0]            r_c_ll;
    logic [32:0]            r_c_upf;
    logic signed [32:0]     r_c_umf;
    logic [31:0]            r_c_uf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
        if (en) begin
            r_c_x   <= r_b_x;
            r_c_y   <= r_b_y;
            r_c_l2  <= r_b_l2;
            r_c_rsq <= {1'b0, r_b_xx} + {1'b0, r_b_yy};
            r_c_ll  <= r_b_ll;
            r_c_upf <= {1'b0, r_b_uu} + {1'b0, r_b_ff};
            r_c_umf <= $signed({1'b0, r_b_uu}) - $signed({1'b0, r_b_ff});
            r_c_uf  <= r_b_uf;
        end
    end

    // stage d: distance squared
    logic [35:0] r_d_rsq;
    t_sq_side    r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_side.valid <= 1'b0;
        end else if (en) begin
            r_d_side.valid <= r_c_valid;
        end
        if (en) begin
            r_d_rsq       <= r_c_rsq;
            r_d_side.x    <= r_c_x;
            r_d_side.y    <= r_c_y;
            r_d_side.l2   <= r_c_l2;
            r_d_side.dsq  <= {1'b0, r_c_rsq} + {1'b0, r_c_ll};
            r_d_side.upf  <= r_c_upf;
            r_d_side.umf  <= r_c_umf;
            r_d_side.uf   <= r_c_uf;
        end
    end

    // reach and distance roots
    logic [SQ_OUT_W-1:0] root_l1;
    logic [SQ_OUT_W-1:0] root_l3;
    t_sq_side            r_sq_side [SQ_OUT_W];

    aik_sqrt u_sqrt_l1 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (SQ_IN_W'(r_d_rsq)),
        .o_root (root_l1)
    );

    aik_sqrt u_sqrt_l3 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (SQ_IN_W'(r_d_side.dsq)),
        .o_root (root_l3)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_OUT_W; k++) begin
                r_sq_side[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_sq_side[0] <= r_d_side;
            for (int k = 1; k < SQ_OUT_W; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    t_sq_side sq_out;
    logic [IN_W:0] l3;
    assign sq_out = r_sq_side[SQ_OUT_W-1];
    assign l3     = root_l3[IN_W:0];

    // stage e: numerators and the shoulder divisor product
    logic                   r_e_valid;
    logic                   r_e_lbad;
    logic signed [IN_W-1:0] r_e_x;
    logic signed [IN_W-1:0] r_e_y;
    logic [IN_W-1:0]        r_e_l1;
    logic signed [IN_W:0]   r_e_l2;
    logic signed [37:0]     r_e_nume;
    logic signed [37:0]     r_e_nums;
    logic [32:0]            r_e_dene;
    logic [34:0]            r_e_ul3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= sq_out.valid;
        end
        if (en) begin
            r_e_lbad <= (r_upper_link == '0) || (r_forearm_link == '0) || (l3 == '0);
            r_e_x    <= sq_out.x;
            r_e_y    <= sq_out.y;
            r_e_l1   <= root_l1[IN_W-1:0];
            r_e_l2   <= sq_out.l2;
            r_e_nume <= $signed({1'b0, sq_out.dsq}) - $signed({5'b0, sq_out.upf});
            r_e_nums <= $signed({1'b0, sq_out.dsq}) + 38'(sq_out.umf);
            r_e_dene <= {sq_out.uf, 1'b0};
            r_e_ul3  <= {19'b0, r_upper_link} * {16'b0, l3};
        end
    end

    // stage f: magnitudes and divisors
    logic                   r_f_valid;
    logic                   r_f_lbad;
    logic                   r_f_neg_e;
    logic                   r_f_neg_s;
    logic signed [IN_W-1:0] r_f_x;
    logic signed [IN_W-1:0] r_f_y;
    logic [IN_W-1:0]        r_f_l1;
    logic signed [IN_W:0]   r_f_l2;
    logic [DIV_W-1:0]       r_f_me;
    logic [DIV_W-1:0]       r_f_ms;
    logic [DIV_W-1:0]       r_f_dene;
    logic [DIV_W-1:0]       r_f_dens;
    logic signed [37:0]     neg_nume;
    logic signed [37:0]     neg_nums;

    assign neg_nume = -r_e_nume;
    assign neg_nums = -r_e_nums;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid;
        end
        if (en) begin
            r_f_lbad  <= r_e_lbad;
            r_f_neg_e <= r_e_nume[37];
            r_f_neg_s <= r_e_nums[37];
            r_f_x     <= r_e_x;
            r_f_y     <= r_e_y;
            r_f_l1    <= r_e_l1;
            r_f_l2    <= r_e_l2;
            r_f_me    <= r_e_nume[37] ? neg_nume[DIV_W-1:0] : r_e_nume[DIV_W-1:0];
            r_f_ms    <= r_e_nums[37] ? neg_nums[DIV_W-1:0] : r_e_nums[DIV_W-1:0];
            r_f_dene  <= {4'b0, r_e_dene};
            r_f_dens  <= {1'b0, r_e_ul3, 1'b0};
        end
    end

    // law of cosines quotients, reach check alongside
    logic [Q_W-1:0] quo_e;
    logic [Q_W-1:0] quo_s;
    t_dv_side       f_side;
    t_dv_side       r_dv_side [Q_W];

    always_comb begin
        f_side.valid = r_f_valid;
        f_side.bad   = r_f_lbad || (r_f_me > r_f_dene) || (r_f_ms > r_f_dens);
        f_side.neg_e = r_f_neg_e;
        f_side.neg_s = r_f_neg_s;
        f_side.x     = r_f_x;
        f_side.y     = r_f_y;
        f_side.l1    = r_f_l1;
        f_side.l2    = r_f_l2;
    end

    aik_div u_div_e (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (r_f_me),
        .i_den (r_f_dene),
        .o_quo (quo_e)
    );

    aik_div u_div_s (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (r_f_ms),
        .i_den (r_f_dens),
        .o_quo (quo_s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Q_W; k++) begin
                r_dv_side[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_dv_side[0] <= f_side;
            for (int k = 1; k < Q_W; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    // stage h: signed cosines
    t_dv_side            dv_out;
    t_dv_side            r_h_side;
    logic [Q_W-1:0]      r_h_qe;
    logic [Q_W-1:0]      r_h_qs;
    logic signed [Q_W:0] r_h_ce;
    logic signed [Q_W:0] r_h_cs;

    assign dv_out = r_dv_side[Q_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_side.valid <= 1'b0;
        end else if (en) begin
            r_h_side <= dv_out;
        end
        if (en) begin
            r_h_qe <= quo_e;
            r_h_qs <= quo_s;
            r_h_ce <= dv_out.neg_e ? -$signed({1'b0, quo_e}) : $signed({1'b0, quo_e});
            r_h_cs <= dv_out.neg_s ? -$signed({1'b0, quo_s}) : $signed({1'b0, quo_s});
        end
    end

    // stage i: cosine squared
    t_dv_side            r_i_side;
    logic [2*Q_W-1:0]    r_i_pe;
    logic [2*Q_W-1:0]    r_i_ps;
    logic signed [Q_W:0] r_i_ce;
    logic signed [Q_W:0] r_i_cs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_side.valid <= 1'b0;
        end else if (en) begin
            r_i_side <= r_h_side;
        end
        if (en) begin
            r_i_pe <= r_h_qe * r_h_qe;
            r_i_ps <= r_h_qs * r_h_qs;
            r_i_ce <= r_h_ce;
            r_i_cs <= r_h_cs;
        end
    end

    // stage j: one minus cosine squared, q.48
    logic [SQ_IN_W-1:0] r_j_ae;
    logic [SQ_IN_W-1:0] r_j_as;
    t_ac_side           r_j_side;
    localparam logic [SQ_IN_W-1:0] ONE_Q48 = SQ_IN_W'(1) << 48;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_side.valid <= 1'b0;
        end else if (en) begin
            r_j_side.valid <= r_i_side.valid;
        end
        if (en) begin
            r_j_ae         <= ONE_Q48 - SQ_IN_W'(r_i_pe);
            r_j_as         <= ONE_Q48 - SQ_IN_W'(r_i_ps);
            r_j_side.bad   <= r_i_side.bad;
            r_j_side.ce    <= r_i_ce;
            r_j_side.cs    <= r_i_cs;
            r_j_side.x     <= r_i_side.x;
            r_j_side.y     <= r_i_side.y;
            r_j_side.l1    <= r_i_side.l1;
            r_j_side.l2    <= r_i_side.l2;
        end
    end

    // sines
    logic [SQ_OUT_W-1:0] sin_e;
    logic [SQ_OUT_W-1:0] sin_s;
    t_ac_side            r_ac_side [SQ_OUT_W];

    aik_sqrt u_sqrt_se (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_j_ae),
        .o_root (sin_e)
    );

    aik_sqrt u_sqrt_ss (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_j_as),
        .o_root (sin_s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_OUT_W; k++) begin
                r_ac_side[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_ac_side[0] <= r_j_side;
            for (int k = 1; k < SQ_OUT_W; k++) begin
                r_ac_side[k] <= r_ac_side[k-1];
            end
        end
    end

    // four arctangents side by side
    t_ac_side             ac_out;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic signed [CW-1:0] sh_x;
    logic signed [CW-1:0] sh_y;
    logic signed [CW-1:0] ae_x;
    logic signed [CW-1:0] ae_y;
    logic signed [CW-1:0] as_x;
    logic signed [CW-1:0] as_y;
    logic signed [ZW-1:0] ang_base;
    logic signed [ZW-1:0] ang_sh;
    logic signed [ZW-1:0] ang_ae;
    logic signed [ZW-1:0] ang_as;

    assign ac_out = r_ac_side[SQ_OUT_W-1];
    assign base_x = CW'(ac_out.x) <<< 16;
    assign base_y = CW'(ac_out.y) <<< 16;
    assign sh_x   = $signed(CW'(ac_out.l1)) <<< 16;
    assign sh_y   = CW'(ac_out.l2) <<< 16;
    assign ae_x   = CW'(ac_out.ce) <<< 8;
    assign ae_y   = $signed(CW'(sin_e)) <<< 8;
    assign as_x   = CW'(ac_out.cs) <<< 8;
    assign as_y   = $signed(CW'(sin_s)) <<< 8;

    aik_cordic u_cordic_base (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (base_x),
        .i_y   (base_y),
        .o_ang (ang_base)
    );

    aik_cordic u_cordic_sh (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (sh_x),
        .i_y   (sh_y),
        .o_ang (ang_sh)
    );

    aik_cordic u_cordic_ae (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (ae_x),
        .i_y   (ae_y),
        .o_ang (ang_ae)
    );

    aik_cordic u_cordic_as (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (as_x),
        .i_y   (as_y),
        .o_ang (ang_as)
    );

    t_co_side r_co_side [CO_LAT];
    t_co_side ac_flags;

    assign ac_flags = '{valid: ac_out.valid, bad: ac_out.bad};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CO_LAT; k++) begin
                r_co_side[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_co_side[0] <= ac_flags;
            for (int k = 1; k < CO_LAT; k++) begin
                r_co_side[k] <= r_co_side[k-1];
            end
        end
    end

    // stage l: shoulder difference
    logic               r_l_valid;
    logic               r_l_bad;
    logic signed [ZW:0] r_l_base;
    logic signed [ZW:0] r_l_sh;
    logic signed [ZW:0] r_l_el;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
        end else if (en) begin
            r_l_valid <= r_co_side[CO_LAT-1].valid;
        end
        if (en) begin
            r_l_bad  <= r_co_side[CO_LAT-1].bad;
            r_l_base <= (ZW+1)'(ang_base);
            r_l_sh   <= (ZW+1)'(ang_sh) - (ZW+1)'(ang_as);
            r_l_el   <= (ZW+1)'(ang_ae);
        end
    end

    // output register, loaded when empty or taken by the consumer; a bubble behind it lets the chain advance
    logic        r_o_valid;
    logic [55:0] r_o_data;
    logic        r_o_user;

    assign out_load = !r_o_valid || m_axis_tready;
    assign en       = out_load || !r_l_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= r_l_valid;
        end
        if (out_load) begin
            r_o_user <= r_l_bad;
            if (r_l_bad) begin
                r_o_data <= '0;
            end else begin
                r_o_data <= {2'b0, to_output(r_l_el), to_output(r_l_sh),
                             to_output(r_l_base)};
            end
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

endmodule
